// ----- hw/rtl/mlr_pkg.sv -----
// ---------------------------------------------------------------------------
// mlr_pkg
// shared constants, types and codes of the midpoint line rasterizer
// ---------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS   = 6;
    localparam int CFG_BITS     = COORD_BITS + 1;
    localparam int COLOR_BITS   = 4;
    localparam int DEC_BITS     = COORD_BITS + 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_ROWS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_COLS = CFG_IDX_BITS'(1);

    localparam logic [CFG_BITS-1:0] CANVAS_RESET = CFG_BITS'(64);

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [CFG_BITS-1:0]        t_canvas;
    typedef logic [COLOR_BITS-1:0]      t_color;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    // one classified line command
    typedef struct packed {
        t_coord major_start;
        t_coord minor_start;
        t_coord major_end;
        t_dec   decision;
        t_dec   inc_straight;
        t_dec   inc_diagonal;
        logic   steep;
        logic   step_down;
        t_color color;
    } t_line;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_walk_state;

endpackage

// ----- hw/rtl/mlr_if.sv -----
// ---------------------------------------------------------------------------
// mlr channel interfaces
// line command, pixel and register write channels
// ---------------------------------------------------------------------------
interface mlr_cmd_if;
    logic                  valid;
    logic                  ready;
    mlr_pkg::t_coord       start_col;
    mlr_pkg::t_coord       start_row;
    mlr_pkg::t_coord       end_col;
    mlr_pkg::t_coord       end_row;
    mlr_pkg::t_color       pen_color;

    modport source (output valid, start_col, start_row, end_col, end_row, pen_color,
                    input ready);
    modport sink   (input valid, start_col, start_row, end_col, end_row, pen_color,
                    output ready);
endinterface

interface mlr_pix_if;
    logic                  valid;
    logic                  ready;
    mlr_pkg::t_coord       pixel_row;
    mlr_pkg::t_coord       pixel_col;
    mlr_pkg::t_color       pixel_color;
    logic                  in_bounds;
    logic                  last_pixel;

    modport source (output valid, pixel_row, pixel_col, pixel_color, in_bounds, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, pixel_color, in_bounds, last_pixel,
                    output ready);
endinterface

interface mlr_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mlr_pkg::CFG_IDX_BITS-1:0]      index;
    logic [mlr_pkg::CFG_BITS-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/mlr_front.sv -----
// ---------------------------------------------------------------------------
// mlr_front
// takes line commands, picks the major axis, orders the endpoints and
// sets up the midpoint decision terms
// ---------------------------------------------------------------------------
module mlr_front (
    mlr_cmd_if.sink        i_cmd,
    input  logic           i_full,
    output logic           o_push,
    output mlr_pkg::t_line o_line
);

    mlr_pkg::t_coord dc;
    mlr_pkg::t_coord dr;
    mlr_pkg::t_coord dx;
    mlr_pkg::t_coord dy;
    mlr_pkg::t_coord a0;
    mlr_pkg::t_coord b0;
    mlr_pkg::t_coord a1;
    mlr_pkg::t_coord b1;
    logic            steep;
    logic            swap;
    mlr_pkg::t_dec   two_dy;
    mlr_pkg::t_dec   two_dx;
    mlr_pkg::t_dec   dx_ext;

    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    always_comb begin
        dc    = (i_cmd.start_col > i_cmd.end_col) ? i_cmd.start_col - i_cmd.end_col
                                                  : i_cmd.end_col - i_cmd.start_col;
        dr    = (i_cmd.start_row > i_cmd.end_row) ? i_cmd.start_row - i_cmd.end_row
                                                  : i_cmd.end_row - i_cmd.start_row;
        steep = dr > dc;
        dx    = steep ? dr : dc;
        dy    = steep ? dc : dr;
        if (steep) begin
            a0 = i_cmd.start_row;
            b0 = i_cmd.start_col;
            a1 = i_cmd.end_row;
            b1 = i_cmd.end_col;
        end else begin
            a0 = i_cmd.start_col;
            b0 = i_cmd.start_row;
            a1 = i_cmd.end_col;
            b1 = i_cmd.end_row;
        end
        swap   = a0 > a1;
        two_dy = mlr_pkg::t_dec'({2'b00, dy, 1'b0});
        two_dx = mlr_pkg::t_dec'({2'b00, dx, 1'b0});
        dx_ext = mlr_pkg::t_dec'({3'b000, dx});

        o_line.major_start  = swap ? a1 : a0;
        o_line.minor_start  = swap ? b1 : b0;
        o_line.major_end    = swap ? a0 : a1;
        o_line.step_down    = swap ? (b1 > b0) : (b0 > b1);
        o_line.steep        = steep;
        o_line.decision     = two_dy - dx_ext;
        o_line.inc_straight = two_dy;
        o_line.inc_diagonal = two_dy - two_dx;
        o_line.color        = i_cmd.pen_color;
    end

endmodule

// ----- hw/rtl/mlr_queue.sv -----
// ---------------------------------------------------------------------------
// mlr_queue
// short queue of classified line commands between front and walker
// ---------------------------------------------------------------------------
module mlr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mlr_pkg::t_line i_data,
    output logic           o_full,
    output logic           o_valid,
    output mlr_pkg::t_line o_data,
    input  logic           i_pop
);

    mlr_pkg::t_line                   r_mem [mlr_pkg::QUEUE_DEPTH];
    logic [mlr_pkg::QPTR_BITS-1:0]    r_wr_ptr;
    logic [mlr_pkg::QPTR_BITS-1:0]    r_rd_ptr;
    logic [mlr_pkg::QCNT_BITS-1:0]    r_count;
    logic [mlr_pkg::QPTR_BITS-1:0]    n_wr_ptr;
    logic [mlr_pkg::QPTR_BITS-1:0]    n_rd_ptr;
    logic [mlr_pkg::QCNT_BITS-1:0]    n_count;

    localparam logic [mlr_pkg::QPTR_BITS-1:0] PTR_LAST =
        mlr_pkg::QPTR_BITS'(mlr_pkg::QUEUE_DEPTH - 1);
    localparam logic [mlr_pkg::QCNT_BITS-1:0] CNT_FULL =
        mlr_pkg::QCNT_BITS'(mlr_pkg::QUEUE_DEPTH);

    assign o_full  = r_count == CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ----- hw/rtl/mlr_back.sv -----
// ---------------------------------------------------------------------------
// mlr_back
// walks one line along its major axis, one pixel per cycle while the pixel
// output is not stalled, into an output register with a canvas bounds flag
// ---------------------------------------------------------------------------
module mlr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mlr_pkg::t_line  i_q_data,
    output logic            o_q_pop,
    input  mlr_pkg::t_canvas i_canvas_rows,
    input  mlr_pkg::t_canvas i_canvas_cols,
    mlr_pix_if.source       o_pix
);

    mlr_pkg::t_walk_state r_state;
    mlr_pkg::t_walk_state n_state;

    mlr_pkg::t_coord r_major;
    mlr_pkg::t_coord r_minor;
    mlr_pkg::t_coord r_major_end;
    mlr_pkg::t_dec   r_decision;
    mlr_pkg::t_dec   r_inc_straight;
    mlr_pkg::t_dec   r_inc_diagonal;
    logic            r_steep;
    logic            r_step_down;
    mlr_pkg::t_color r_color;

    logic            r_vld;
    mlr_pkg::t_coord r_row;
    mlr_pkg::t_coord r_col;
    mlr_pkg::t_color r_pix_color;
    logic            r_inb;
    logic            r_last;

    logic            fire;
    logic            at_end;
    logic            go_straight;
    mlr_pkg::t_coord cur_row;
    mlr_pkg::t_coord cur_col;

    assign at_end      = r_major == r_major_end;
    assign go_straight = r_decision[mlr_pkg::DEC_BITS-1] || (r_decision == '0);
    assign cur_row     = r_steep ? r_major : r_minor;
    assign cur_col     = r_steep ? r_minor : r_major;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = mlr_pkg::ST_WALK;
                end
            end
            mlr_pkg::ST_WALK: begin
                if (fire && at_end) begin
                    n_state = mlr_pkg::ST_IDLE;
                end
            end
            default: n_state = mlr_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        fire    = 1'b0;
        unique case (r_state)
            mlr_pkg::ST_IDLE: o_q_pop = i_q_valid;
            mlr_pkg::ST_WALK: fire    = !r_vld || o_pix.ready;
            default: begin
                o_q_pop = 1'b0;
                fire    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlr_pkg::ST_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_vld <= 1'b1;
            end else if (o_pix.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_major        <= i_q_data.major_start;
            r_minor        <= i_q_data.minor_start;
            r_major_end    <= i_q_data.major_end;
            r_decision     <= i_q_data.decision;
            r_inc_straight <= i_q_data.inc_straight;
            r_inc_diagonal <= i_q_data.inc_diagonal;
            r_steep        <= i_q_data.steep;
            r_step_down    <= i_q_data.step_down;
            r_color        <= i_q_data.color;
        end else if (fire && !at_end) begin
            r_major <= r_major + 1'b1;
            if (go_straight) begin
                r_decision <= r_decision + r_inc_straight;
            end else begin
                r_decision <= r_decision + r_inc_diagonal;
                r_minor    <= r_step_down ? r_minor - 1'b1 : r_minor + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_row       <= cur_row;
            r_col       <= cur_col;
            r_pix_color <= r_color;
            r_inb       <= ({1'b0, cur_row} < i_canvas_rows) &&
                           ({1'b0, cur_col} < i_canvas_cols);
            r_last      <= at_end;
        end
    end

    assign o_pix.valid       = r_vld;
    assign o_pix.pixel_row   = r_row;
    assign o_pix.pixel_col   = r_col;
    assign o_pix.pixel_color = r_pix_color;
    assign o_pix.in_bounds   = r_inb;
    assign o_pix.last_pixel  = r_last;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mlr_pkg::ST_WALK |-> r_major <= r_major_end)
        else $error("walker passed the line end");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && at_end |=> r_state == mlr_pkg::ST_IDLE && r_vld && r_last)
        else $error("last pixel did not close the line");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid && !fire)
        else $error("command taken while walking");

endmodule

// ----- hw/rtl/midpoint_line_rasterizer_top.sv -----
// first pixel of a line goes through the queue, walker idle state and output register
// the walker pops the next line only after the last pixel of the current one
// walker sets the rate: idle pop state, then one pixel per cycle unless output stalls
// a two-entry command queue lets the front take commands while a line is walked
// reset: queue emptied, walker idle, no pixel valid, canvas size back to 64 x 64
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// midpoint line rasterizer: command front end, queue, pixel walker, registers
// ---------------------------------------------------------------------------
module midpoint_line_rasterizer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mlr_cmd_if.sink  i_cmd,
    mlr_cfg_if.sink  i_cfg,
    mlr_pix_if.source o_pix
);

    mlr_pkg::t_canvas r_canvas_rows;
    mlr_pkg::t_canvas r_canvas_cols;

    logic           q_full;
    logic           q_push;
    mlr_pkg::t_line q_in;
    logic           q_valid;
    mlr_pkg::t_line q_out;
    logic           q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_rows <= mlr_pkg::CANVAS_RESET;
            r_canvas_cols <= mlr_pkg::CANVAS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mlr_pkg::REG_CANVAS_ROWS: r_canvas_rows <= i_cfg.data;
                mlr_pkg::REG_CANVAS_COLS: r_canvas_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mlr_front u_front (
        .i_cmd  (i_cmd),
        .i_full (q_full),
        .o_push (q_push),
        .o_line (q_in)
    );

    mlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    mlr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .i_canvas_rows (r_canvas_rows),
        .i_canvas_cols (r_canvas_cols),
        .o_pix         (o_pix)
    );

endmodule
